// ===== hw/rtl/h264_rtp_fua_packetizer_unit_assert.svh =====
// Assertion macros shared by the packetizer RTL.
`ifndef H264_RTP_FUA_PACKETIZER_UNIT_ASSERT_SVH
`define H264_RTP_FUA_PACKETIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define H264FUA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define H264FUA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/h264fua_pkg.sv =====
// Package: types, constants and register indexes of the FU-A packetizer.
package h264fua_pkg;

    localparam int unsigned MAX_NAL_BYTES_DEF = 1048575;
    localparam int unsigned NAL_SIZE_W        = 20;
    localparam int unsigned PAYLOAD_W         = 11;
    localparam int unsigned TS_STEP_W         = 17;
    localparam int unsigned SEQ_W             = 16;
    localparam int unsigned TS_W              = 32;

    localparam logic [PAYLOAD_W-1:0] PAYLOAD_MIN   = 11'd16;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX   = 11'd1460;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 11'd1400;
    localparam logic [TS_STEP_W-1:0] TS_STEP_RESET = 17'(90000 / 25);

    localparam logic [7:0] NRI_MASK     = 8'h60;
    localparam logic [7:0] TYPE_MASK    = 8'h1F;
    localparam logic [7:0] FU_A_TYPE    = 8'd28;
    localparam logic [7:0] FU_S_BIT     = 8'h80;
    localparam logic [7:0] FU_E_BIT     = 8'h40;
    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] CFG_TS_STEP     = 2'd1;

    // result slot within one queued item
    localparam logic [1:0] SLOT_FU_IND = 2'd0;
    localparam logic [1:0] SLOT_FU_HDR = 2'd1;
    localparam logic [1:0] SLOT_DATA   = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 4;

    // everything one input byte produces: optional FU indicator/header plus the data byte
    typedef struct packed {
        logic             has_hdr;
        logic [7:0]       fu_ind;
        logic [7:0]       fu_hdr;
        logic [7:0]       data;
        logic             data_start;
        logic             data_end;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
    } t_entry;

endpackage

// ===== hw/rtl/h264fua_queue.sv =====
// Result queue: holds per-byte entries and plays them out as 1 or 3 payload bytes.
module h264fua_queue
    import h264fua_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_entry      i_entry,
    output logic        o_ready,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [55:0] o_tdata,
    output logic [1:0]  o_tuser,
    output logic        o_tlast
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [1:0]         r_slot;
    t_entry             head;
    logic               on_data;
    logic               xfer, pop;
    logic [7:0]         out_byte;
    logic               out_start, out_end;

    assign head     = r_mem[r_rd_ptr];
    assign o_tvalid = (r_count != '0);
    assign o_ready  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign on_data  = !head.has_hdr || (r_slot == SLOT_DATA);
    assign xfer     = o_tvalid && i_tready;
    assign pop      = xfer && on_data;

    always_comb begin
        out_byte  = head.data;
        out_start = head.data_start;
        out_end   = head.data_end;
        if (!on_data) begin
            out_end = 1'b0;
            case (r_slot)
                SLOT_FU_IND: begin
                    out_byte  = head.fu_ind;
                    out_start = 1'b1;
                end
                SLOT_FU_HDR: begin
                    out_byte  = head.fu_hdr;
                    out_start = 1'b0;
                end
                default: begin
                    out_byte  = head.data;
                    out_start = head.data_start;
                end
            endcase
        end
    end

    assign o_tdata = {head.ts, head.seq, out_byte};
    assign o_tuser = {on_data, out_start};
    assign o_tlast = out_end;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_slot   <= SLOT_FU_IND;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_slot   <= SLOT_FU_IND;
            end else if (xfer) begin
                r_slot <= r_slot + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`include "h264_rtp_fua_packetizer_unit_assert.svh"

    `H264FUA_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, r_count != CNT_W'(QUEUE_DEPTH) || pop, "queue push while full")
    `H264FUA_ASSERT_NEXT(a_item_continues, i_clk, i_rst_n, xfer && !on_data, o_tvalid && !on_data || o_tvalid && on_data, "entry lost mid-item")
    `H264FUA_ASSERT_SAME(a_slot_idle, i_clk, i_rst_n, !o_tvalid, r_slot == SLOT_FU_IND, "slot index not at start while empty")

endmodule

// ===== hw/rtl/h264_rtp_fua_packetizer_unit.sv =====
// Top level: H.264 NAL unit to RTP payload packetizer, single NAL or FU-A fragments.
//
// Feed one NAL byte per transfer on the slave stream, start code removed, with
// tuser high and the unit size in tdata on the header byte. Units up to
// max_payload bytes (clamped to 16..1460) leave as one RTP payload; larger
// units become FU-A fragments of up to max_payload data bytes, each led by a
// FU indicator and a FU header (S on the first, E on the last). The header
// byte of a fragmented unit yields no output. Each output byte carries the
// packet's sequence number and the unit's timestamp; tlast marks the last
// byte of a packet, tuser[0] the first, tuser[1] the last byte produced by
// one input byte. Throughput is one input byte per cycle while the four-entry
// result queue between the per-byte logic and the output port has room; the
// byte that opens a fragment yields three output bytes, and the input stalls
// whenever the queue is full. Config writes (index 0 max_payload, index 1
// timestamp_step) are always accepted and should only be made while the
// block is idle.
module h264_rtp_fua_packetizer_unit
    import h264fua_pkg::*;
#(
    parameter int unsigned P_MAX_NAL_BYTES = MAX_NAL_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [7:0] nal_byte, [27:8] nal_size, [31:28] zero
    input  logic        i_s_axis_tuser,  // [0] first_of_nal
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,  // [7:0] out_byte, [23:8] seq_number, [55:24] rtp_timestamp
    output logic [1:0]  o_m_axis_tuser,  // [0] packet_start, [1] last_of_item
    output logic        o_m_axis_tlast,  // packet_end
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam logic [NAL_SIZE_W-1:0] MAX_SIZE = NAL_SIZE_W'(P_MAX_NAL_BYTES);

    // config
    logic [PAYLOAD_W-1:0]  r_max_payload;
    logic [TS_STEP_W-1:0]  r_ts_step;

    // packetizer state
    logic [7:0]            r_nal_hdr,    n_nal_hdr;
    logic                  r_frag,       n_frag;
    logic [NAL_SIZE_W-1:0] r_bytes_left, n_bytes_left;
    logic [PAYLOAD_W-1:0]  r_fill,       n_fill;
    logic                  r_first_frag, n_first_frag;
    logic [SEQ_W-1:0]      r_seq,        n_seq;
    logic [TS_W-1:0]       r_ts,         n_ts;

    logic                  accept;
    logic                  q_ready;
    logic                  push;
    t_entry                entry;

    logic [7:0]            in_byte;
    logic                  in_first;
    logic [NAL_SIZE_W-1:0] in_size, size_sat;
    logic [PAYLOAD_W-1:0]  lim_p, lim_frag;
    logic [4:0]            cur_type;
    logic [TS_W-1:0]       ts_adv;
    logic                  last;
    logic [NAL_SIZE_W-1:0] left_dec;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= PAYLOAD_RESET;
            r_ts_step     <= TS_STEP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[PAYLOAD_W-1:0];
                CFG_TS_STEP:     r_ts_step     <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    assign in_byte  = i_s_axis_tdata[7:0];
    assign in_size  = i_s_axis_tdata[27:8];
    assign in_first = i_s_axis_tuser;
    assign accept   = i_s_axis_tvalid && q_ready;
    assign o_s_axis_tready = q_ready;

    // size of zero counts as one, oversize clips
    always_comb begin
        size_sat = in_size;
        if (in_size == '0) begin
            size_sat = NAL_SIZE_W'(1);
        end else if (in_size > MAX_SIZE) begin
            size_sat = MAX_SIZE;
        end
    end

    always_comb begin
        lim_p = r_max_payload;
        if (r_max_payload < PAYLOAD_MIN) begin
            lim_p = PAYLOAD_MIN;
        end else if (r_max_payload > PAYLOAD_MAX) begin
            lim_p = PAYLOAD_MAX;
        end
    end

    // a fragment may not carry both S and E: shorten the first one by a byte
    assign lim_frag = (r_first_frag &&
                       ({1'b0, r_bytes_left} + (NAL_SIZE_W + 1)'(r_fill)
                        == (NAL_SIZE_W + 1)'(lim_p))) ? lim_p - 1'b1 : lim_p;

    assign ts_adv   = r_ts + TS_W'(r_ts_step);
    assign left_dec = r_bytes_left - 1'b1;

    always_comb begin
        n_nal_hdr    = r_nal_hdr;
        n_frag       = r_frag;
        n_bytes_left = r_bytes_left;
        n_fill       = r_fill;
        n_first_frag = r_first_frag;
        n_seq        = r_seq;
        n_ts         = r_ts;
        push         = 1'b0;
        last         = 1'b0;
        cur_type     = r_nal_hdr[4:0];

        entry.has_hdr    = 1'b0;
        entry.fu_ind     = (r_nal_hdr & NRI_MASK) | FU_A_TYPE;
        entry.fu_hdr     = r_nal_hdr & TYPE_MASK;
        entry.data       = in_byte;
        entry.data_start = 1'b0;
        entry.data_end   = 1'b0;
        entry.seq        = r_seq;
        entry.ts         = r_ts;

        if (accept) begin
            if (in_first) begin
                cur_type     = in_byte[4:0];
                n_nal_hdr    = in_byte;
                n_bytes_left = size_sat - 1'b1;
                n_fill       = '0;
                n_first_frag = 1'b1;
                if (size_sat <= NAL_SIZE_W'(lim_p)) begin
                    n_frag           = 1'b0;
                    push             = 1'b1;
                    entry.data_start = 1'b1;
                    entry.data_end   = (size_sat == NAL_SIZE_W'(1));
                    if (size_sat == NAL_SIZE_W'(1)) begin
                        n_seq = r_seq + 1'b1;
                        if (cur_type != NAL_TYPE_SPS && cur_type != NAL_TYPE_PPS) begin
                            n_ts = ts_adv;
                        end
                    end
                end else begin
                    n_frag = 1'b1;
                end
            end else if (r_bytes_left == '0) begin
                // stray byte, no open unit
            end else if (!r_frag) begin
                last           = (r_bytes_left == NAL_SIZE_W'(1));
                push           = 1'b1;
                entry.data_end = last;
                n_bytes_left   = left_dec;
                if (last) begin
                    n_seq = r_seq + 1'b1;
                    if (cur_type != NAL_TYPE_SPS && cur_type != NAL_TYPE_PPS) begin
                        n_ts = ts_adv;
                    end
                end
            end else begin
                push = 1'b1;
                if (r_fill == '0) begin
                    entry.has_hdr = 1'b1;
                    if (r_first_frag) begin
                        entry.fu_hdr = (r_nal_hdr & TYPE_MASK) | FU_S_BIT;
                    end else if (r_bytes_left <= NAL_SIZE_W'(lim_p)) begin
                        entry.fu_hdr = (r_nal_hdr & TYPE_MASK) | FU_E_BIT;
                    end
                end
                last = (r_bytes_left == NAL_SIZE_W'(1)) ||
                       ({1'b0, r_fill} + 1'b1 >= {1'b0, lim_frag});
                entry.data_end = last;
                n_fill         = r_fill + 1'b1;
                n_bytes_left   = left_dec;
                if (last) begin
                    n_fill       = '0;
                    n_first_frag = 1'b0;
                    n_seq        = r_seq + 1'b1;
                    if (left_dec == '0) begin
                        n_ts   = ts_adv;
                        n_frag = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nal_hdr    <= '0;
            r_frag       <= 1'b0;
            r_bytes_left <= '0;
            r_fill       <= '0;
            r_first_frag <= 1'b1;
            r_seq        <= '0;
            r_ts         <= '0;
        end else begin
            r_nal_hdr    <= n_nal_hdr;
            r_frag       <= n_frag;
            r_bytes_left <= n_bytes_left;
            r_fill       <= n_fill;
            r_first_frag <= n_first_frag;
            r_seq        <= n_seq;
            r_ts         <= n_ts;
        end
    end

    h264fua_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .o_ready  (q_ready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

`include "h264_rtp_fua_packetizer_unit_assert.svh"

    `H264FUA_ASSERT_SAME(a_fill_idle, i_clk, i_rst_n, !r_frag, r_fill == '0, "fragment fill set outside fragment mode")
    `H264FUA_ASSERT_SAME(a_frag_open, i_clk, i_rst_n, r_frag, r_bytes_left != '0, "fragment mode with no bytes left")
    `H264FUA_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill < PAYLOAD_MAX, "fragment fill beyond payload limit")

endmodule
